// File: hdl/crcfr_pkg.sv
// Package with constants, types and the CRC step function of the framed packet receiver.
package crcfr_pkg;

   localparam int BUFFER_LIMIT = 512;
   localparam int AW = $clog2(BUFFER_LIMIT);
   localparam int FW = $clog2(BUFFER_LIMIT + 1);

   localparam logic [7:0]  SYNC_BYTE = 8'hFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;

   localparam logic [1:0] KIND_ACCEPT   = 2'd0;
   localparam logic [1:0] KIND_REJECT   = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;
   localparam logic [1:0] KIND_READ     = 2'd3;

   localparam logic OPC_BYTE = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_LEN_RD, ST_LEN_CHK, ST_CRC_RD, ST_CRC_UP,
      ST_LO_RD, ST_LO_GET, ST_HI_GET, ST_MSG_GET, ST_DECIDE,
      ST_COPY_RD, ST_COPY_WR, ST_SCAN_RD, ST_SCAN_CHK, ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_ACCEPT, DP_READ, DP_RD_LEN, DP_LEN, DP_RD_CNT, DP_CRC,
      DP_RD_LO, DP_GET_LO, DP_GET_HI, DP_GET_MSG, DP_DECIDE,
      DP_RD_COPY, DP_COPY, DP_SCAN_RD, DP_SCAN, DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic drop;
      logic full;
      logic fill_ge3;
      logic len_match;
      logic crc_last;
      logic accept;
      logic copy_last;
      logic scan_end;
      logic scan_hit;
      logic slot_free;
   } status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      begin
         c = crc ^ {8'h00, data};
         for (int b = 0; b < 8; b++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
         end
         return c;
      end
   endfunction

endpackage

// File: hdl/crcfr_req_if.sv
// Request channel interface carrying received bytes and read requests.
interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, opcode, rx_byte, read_index, input ready);
   modport sink (input valid, opcode, rx_byte, read_index, output ready);
endinterface

// File: hdl/crcfr_rsp_if.sv
// Response channel interface carrying frame results and read data.
interface crcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [8:0]  payload_length;
   logic [7:0]  message_type;
   logic        crc_swapped;
   logic        crc_mismatch_bypassed;
   logic [15:0] calc_crc;
   logic [15:0] frame_crc;
   logic [7:0]  read_data;
   logic        read_out_of_range;

   modport source (output valid, result_kind, payload_length, message_type, crc_swapped,
                   crc_mismatch_bypassed, calc_crc, frame_crc, read_data,
                   read_out_of_range, input ready);
   modport sink (input valid, result_kind, payload_length, message_type, crc_swapped,
                 crc_mismatch_bypassed, calc_crc, frame_crc, read_data,
                 read_out_of_range, output ready);
endinterface

// File: hdl/crcfr_ctrl.sv
// Controller state machine that sequences the receive, check, copy, trim, read and emit steps.
module crcfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  crcfr_pkg::status_type st,
   output crcfr_pkg::cmd_type    cmd
);
   import crcfr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (st.is_read) state_in = ST_READ;
               else if (st.drop) state_in = ST_IDLE;
               else if (st.full) state_in = ST_EMIT;
               else if (st.fill_ge3) state_in = ST_LEN_RD;
            end
         end
         ST_READ:    state_in = ST_EMIT;
         ST_LEN_RD:  state_in = ST_LEN_CHK;
         ST_LEN_CHK: state_in = st.len_match ? ST_CRC_RD : ST_IDLE;
         ST_CRC_RD:  state_in = ST_CRC_UP;
         ST_CRC_UP:  state_in = st.crc_last ? ST_LO_RD : ST_CRC_RD;
         ST_LO_RD:   state_in = ST_LO_GET;
         ST_LO_GET:  state_in = ST_HI_GET;
         ST_HI_GET:  state_in = ST_MSG_GET;
         ST_MSG_GET: state_in = ST_DECIDE;
         ST_DECIDE:  state_in = st.accept ? ST_COPY_RD : ST_SCAN_RD;
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: state_in = st.copy_last ? ST_EMIT : ST_COPY_RD;
         ST_SCAN_RD: state_in = st.scan_end ? ST_EMIT : ST_SCAN_CHK;
         ST_SCAN_CHK: state_in = st.scan_hit ? ST_EMIT : ST_SCAN_RD;
         ST_EMIT:    state_in = st.slot_free ? ST_IDLE : ST_EMIT;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op = DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = DP_ACCEPT;
         end
         ST_READ:     cmd.op = DP_READ;
         ST_LEN_RD:   cmd.op = DP_RD_LEN;
         ST_LEN_CHK:  cmd.op = DP_LEN;
         ST_CRC_RD:   cmd.op = DP_RD_CNT;
         ST_CRC_UP:   cmd.op = DP_CRC;
         ST_LO_RD:    cmd.op = DP_RD_LO;
         ST_LO_GET:   cmd.op = DP_GET_LO;
         ST_HI_GET:   cmd.op = DP_GET_HI;
         ST_MSG_GET:  cmd.op = DP_GET_MSG;
         ST_DECIDE:   cmd.op = DP_DECIDE;
         ST_COPY_RD:  cmd.op = DP_RD_COPY;
         ST_COPY_WR:  cmd.op = DP_COPY;
         ST_SCAN_RD:  cmd.op = DP_SCAN_RD;
         ST_SCAN_CHK: cmd.op = DP_SCAN;
         ST_EMIT:     cmd.op = st.slot_free ? DP_EMIT : DP_NOP;
         default:     cmd.op = DP_NOP;
      endcase
   end
endmodule

// File: hdl/crcfr_dp.sv
// Datapath with the receive ring, frame store, CRC register and result registers.
module crcfr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  crcfr_pkg::cmd_type    cmd,
   output crcfr_pkg::status_type st,
   input  logic                  csr_we,
   input  logic                  csr_wdata,
   input  logic                  in_opcode,
   input  logic [7:0]            in_rx_byte,
   input  logic [7:0]            in_read_index,
   input  logic                  out_ready,
   output logic                  out_valid,
   output logic [1:0]            out_result_kind,
   output logic [8:0]            out_payload_length,
   output logic [7:0]            out_message_type,
   output logic                  out_crc_swapped,
   output logic                  out_crc_mismatch_bypassed,
   output logic [15:0]           out_calc_crc,
   output logic [15:0]           out_frame_crc,
   output logic [7:0]            out_read_data,
   output logic                  out_read_out_of_range
);
   import crcfr_pkg::*;

   function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [FW-1:0] off);
      logic [FW:0] s;
      begin
         s = (FW+1)'(h) + (FW+1)'(off);
         if (s >= (FW+1)'(BUFFER_LIMIT)) s = s - (FW+1)'(BUFFER_LIMIT);
         return s[AW-1:0];
      end
   endfunction

   logic [7:0] rx_mem [BUFFER_LIMIT];
   logic [7:0] frame_mem [256];

   logic [AW-1:0] head_ff, head_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] cnt_ff, cnt_in;
   logic [8:0]    plen_ff, plen_in;
   logic [8:0]    flen_ff, flen_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    lo_ff, lo_in, hi_ff, hi_in, msg_ff, msg_in;
   logic [7:0]    mem_q_ff, frame_q_ff;
   logic [7:0]    idx_ff;
   logic          bypass_ff;

   logic [1:0]  p_kind_ff, p_kind_in;
   logic [8:0]  p_plen_ff, p_plen_in;
   logic [7:0]  p_msg_ff, p_msg_in;
   logic        p_swap_ff, p_swap_in, p_byp_ff, p_byp_in;
   logic [15:0] p_comp_ff, p_comp_in, p_recv_ff, p_recv_in;
   logic [7:0]  p_rdata_ff, p_rdata_in;
   logic        p_oor_ff, p_oor_in;
   logic        rsp_valid_ff;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [15:0]   received, swapped;
   logic          match, swap_match, acc;

   assign received   = {hi_ff, lo_ff};
   assign swapped    = {lo_ff, hi_ff};
   assign match      = (received == crc_ff);
   assign swap_match = (swapped == crc_ff);
   assign acc        = match || bypass_ff || swap_match;

   always_comb begin
      st.is_read   = (in_opcode != OPC_BYTE);
      st.drop      = (fill_ff == '0) && (in_rx_byte != SYNC_BYTE);
      st.full      = (fill_ff >= FW'(BUFFER_LIMIT));
      st.fill_ge3  = (fill_ff >= FW'(3));
      st.len_match = (fill_ff == FW'(mem_q_ff) + FW'(5));
      st.crc_last  = (cnt_ff == FW'(plen_ff) + FW'(1));
      st.accept    = acc;
      st.copy_last = (cnt_ff == FW'(plen_ff) - FW'(1));
      st.scan_end  = (cnt_ff >= fill_ff);
      st.scan_hit  = (mem_q_ff == SYNC_BYTE);
      st.slot_free = !rsp_valid_ff || out_ready;
   end

   always_comb begin
      head_in = head_ff; fill_in = fill_ff; cnt_in = cnt_ff; plen_in = plen_ff;
      flen_in = flen_ff; crc_in = crc_ff; lo_in = lo_ff; hi_in = hi_ff; msg_in = msg_ff;
      p_kind_in = p_kind_ff; p_plen_in = p_plen_ff; p_msg_in = p_msg_ff;
      p_swap_in = p_swap_ff; p_byp_in = p_byp_ff; p_comp_in = p_comp_ff;
      p_recv_in = p_recv_ff; p_rdata_in = p_rdata_ff; p_oor_in = p_oor_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = ring(head_ff, fill_ff);
      case (cmd.op)
         DP_ACCEPT: begin
            if (!st.is_read && !st.drop) begin
               if (st.full) begin
                  fill_in = '0;
                  p_kind_in = KIND_OVERFLOW; p_plen_in = '0; p_msg_in = '0;
                  p_swap_in = 1'b0; p_byp_in = 1'b0; p_comp_in = '0; p_recv_in = '0;
                  p_rdata_in = '0; p_oor_in = 1'b0;
               end else begin
                  wr_en = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         DP_READ: begin
            p_kind_in = KIND_READ; p_plen_in = '0; p_msg_in = '0;
            p_swap_in = 1'b0; p_byp_in = 1'b0; p_comp_in = '0; p_recv_in = '0;
            p_oor_in = !({1'b0, idx_ff} < flen_ff);
            p_rdata_in = p_oor_in ? 8'h00 : frame_q_ff;
         end
         DP_RD_LEN: begin
            rd_en = 1'b1; rd_addr = ring(head_ff, FW'(1));
         end
         DP_LEN: begin
            plen_in = {1'b0, mem_q_ff} + 9'd1;
            cnt_in = '0;
            crc_in = CRC_INIT;
         end
         DP_RD_CNT: begin
            rd_en = 1'b1; rd_addr = ring(head_ff, cnt_ff);
         end
         DP_CRC: begin
            crc_in = crc_byte(crc_ff, mem_q_ff);
            cnt_in = cnt_ff + FW'(1);
         end
         DP_RD_LO: begin
            rd_en = 1'b1; rd_addr = ring(head_ff, FW'(plen_ff) + FW'(2));
         end
         DP_GET_LO: begin
            lo_in = mem_q_ff;
            rd_en = 1'b1; rd_addr = ring(head_ff, FW'(plen_ff) + FW'(3));
         end
         DP_GET_HI: begin
            hi_in = mem_q_ff;
            rd_en = 1'b1; rd_addr = ring(head_ff, FW'(2));
         end
         DP_GET_MSG: msg_in = mem_q_ff;
         DP_DECIDE: begin
            p_kind_in = acc ? KIND_ACCEPT : KIND_REJECT;
            p_plen_in = plen_ff; p_msg_in = msg_ff;
            p_swap_in = !match && !bypass_ff && swap_match;
            p_byp_in = bypass_ff && !match;
            p_comp_in = crc_ff; p_recv_in = received;
            p_rdata_in = '0; p_oor_in = 1'b0;
            cnt_in = acc ? FW'(0) : FW'(1);
         end
         DP_RD_COPY: begin
            rd_en = 1'b1; rd_addr = ring(head_ff, cnt_ff + FW'(2));
         end
         DP_COPY: begin
            cnt_in = cnt_ff + FW'(1);
            if (st.copy_last) begin
               flen_in = plen_ff;
               fill_in = '0;
            end
         end
         DP_SCAN_RD: begin
            if (st.scan_end) fill_in = '0;
            else begin
               rd_en = 1'b1; rd_addr = ring(head_ff, cnt_ff);
            end
         end
         DP_SCAN: begin
            if (st.scan_hit) begin
               head_in = ring(head_ff, cnt_ff);
               fill_in = fill_ff - cnt_ff;
            end else cnt_in = cnt_ff + FW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) rx_mem[wr_addr] <= in_rx_byte;
      if (rd_en) mem_q_ff <= rx_mem[rd_addr];
      if (cmd.op == DP_COPY) frame_mem[cnt_ff[7:0]] <= mem_q_ff;
      if (cmd.op == DP_ACCEPT) begin
         frame_q_ff <= frame_mem[in_read_index];
         idx_ff <= in_read_index;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; plen_ff <= plen_in; crc_ff <= crc_in;
      lo_ff <= lo_in; hi_ff <= hi_in; msg_ff <= msg_in;
      p_kind_ff <= p_kind_in; p_plen_ff <= p_plen_in; p_msg_ff <= p_msg_in;
      p_swap_ff <= p_swap_in; p_byp_ff <= p_byp_in; p_comp_ff <= p_comp_in;
      p_recv_ff <= p_recv_in; p_rdata_ff <= p_rdata_in; p_oor_ff <= p_oor_in;
      if (cmd.op == DP_EMIT) begin
         out_result_kind <= p_kind_ff; out_payload_length <= p_plen_ff;
         out_message_type <= p_msg_ff; out_crc_swapped <= p_swap_ff;
         out_crc_mismatch_bypassed <= p_byp_ff; out_calc_crc <= p_comp_ff;
         out_frame_crc <= p_recv_ff; out_read_data <= p_rdata_ff;
         out_read_out_of_range <= p_oor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         flen_ff <= '0;
         bypass_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         flen_ff <= flen_in;
         if (csr_we) bypass_ff <= csr_wdata;
         if (cmd.op == DP_EMIT) rsp_valid_ff <= 1'b1;
         else if (out_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign out_valid = rsp_valid_ff;
endmodule

// File: hdl/crc16_framed_packet_receiver.sv
// Top level of the CRC-16 framed packet receiver joining controller and datapath.
//
//   channel   direction   contents
//   req_ch    in          opcode, rx_byte, read_index
//   rsp_ch    out         frame check result, overflow notice or read data
//   csr       in          bypass_crc write
//
// A dropped byte, or a stored byte that leaves the fill below four, is taken in the idle
// state alone; a stored byte that leaves four or more also reads and checks the length.
// A completing byte then runs the CRC over header and payload, fetches both CRC bytes and
// the message type and decides; it copies the payload on accept or scans for the next sync
// byte on reject, then emits. A read fetches its byte, then emits; an overflow emits at
// once. Reset is synchronous and empties both stores; no clearing pass. A result waits in
// the output register; the next word is taken while it is held.
module crc16_framed_packet_receiver (
   input  logic        clock,
   input  logic        reset,
   crcfr_req_if.sink   req_ch,
   crcfr_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import crcfr_pkg::*;

   cmd_type    cmd;
   status_type st;

   crcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   crcfr_dp u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .st                        (st),
      .csr_we                    (csr_we),
      .csr_wdata                 (csr_wdata),
      .in_opcode                 (req_ch.opcode),
      .in_rx_byte                (req_ch.rx_byte),
      .in_read_index             (req_ch.read_index),
      .out_ready                 (rsp_ch.ready),
      .out_valid                 (rsp_ch.valid),
      .out_result_kind           (rsp_ch.result_kind),
      .out_payload_length        (rsp_ch.payload_length),
      .out_message_type          (rsp_ch.message_type),
      .out_crc_swapped           (rsp_ch.crc_swapped),
      .out_crc_mismatch_bypassed (rsp_ch.crc_mismatch_bypassed),
      .out_calc_crc              (rsp_ch.calc_crc),
      .out_frame_crc             (rsp_ch.frame_crc),
      .out_read_data             (rsp_ch.read_data),
      .out_read_out_of_range     (rsp_ch.read_out_of_range)
   );
endmodule

// File: bench/crc16_framed_packet_receiver_test.sv
`timescale 1ns / 1ps
// Testbench for the CRC-16 framed packet receiver: random framed traffic, reads and checks.
module crc16_framed_packet_receiver_test;
   import crcfr_pkg::*;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } word_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [8:0]  payload_length;
      logic [7:0]  message_type;
      logic        crc_swapped;
      logic        crc_mismatch_bypassed;
      logic [15:0] calc_crc;
      logic [15:0] frame_crc;
      logic [7:0]  read_data;
      logic        read_out_of_range;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;

   crcfr_req_if req_ch ();
   crcfr_rsp_if rsp_ch ();

   crc16_framed_packet_receiver dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   word_type   pending_words[$];
   result_type expected_results[$];
   int         failures = 0;
   bit         hold_sender = 0;

   logic [7:0] ring[BUFFER_LIMIT];
   int         ring_fill = 0;
   logic [7:0] payload_copy[256];
   int         stored_length = 0;
   logic       bypass = 1'b0;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   task automatic predict_word(input word_type w);
      result_type r;
      int plen, skip;
      logic [15:0] crc, rcv, swp;
      r = '0;
      if (w.opcode != OPC_BYTE) begin
         r.result_kind = KIND_READ;
         if (w.read_index < stored_length) r.read_data = payload_copy[w.read_index];
         else r.read_out_of_range = 1'b1;
         expected_results.insert(expected_results.size(), r);
         return;
      end
      if (ring_fill == 0 && w.rx_byte != SYNC_BYTE) return;
      if (ring_fill >= BUFFER_LIMIT) begin
         ring_fill = 0;
         r.result_kind = KIND_OVERFLOW;
         expected_results.insert(expected_results.size(), r);
         return;
      end
      ring[ring_fill] = w.rx_byte;
      ring_fill++;
      if (ring_fill < 4) return;
      plen = ring[1] + 1;
      if (ring_fill != plen + 4) return;
      crc = CRC_INIT;
      for (int i = 0; i < plen + 2; i++) crc = crc_step(crc, ring[i]);
      rcv = {ring[plen + 3], ring[plen + 2]};
      swp = {ring[plen + 2], ring[plen + 3]};
      r.payload_length = 9'(plen);
      r.message_type = ring[2];
      r.calc_crc = crc;
      r.frame_crc = rcv;
      if (rcv == crc || bypass) begin
         r.result_kind = KIND_ACCEPT;
         r.crc_mismatch_bypassed = (rcv != crc);
      end else if (swp == crc) begin
         r.result_kind = KIND_ACCEPT;
         r.crc_swapped = 1'b1;
      end else begin
         r.result_kind = KIND_REJECT;
         skip = 1;
         while (skip < ring_fill && ring[skip] != SYNC_BYTE) skip++;
         if (skip >= ring_fill) ring_fill = 0;
         else begin
            for (int i = 0; i < ring_fill - skip; i++) ring[i] = ring[i + skip];
            ring_fill -= skip;
         end
         expected_results.insert(expected_results.size(), r);
         return;
      end
      for (int i = 0; i < plen; i++) payload_copy[i] = ring[2 + i];
      stored_length = plen;
      ring_fill = 0;
      expected_results.insert(expected_results.size(), r);
   endtask

   function automatic word_type rx_word(input logic [7:0] b);
      word_type w;
      w.opcode = OPC_BYTE;
      w.rx_byte = b;
      w.read_index = $urandom_range(0, 255);
      return w;
   endfunction

   function automatic word_type read_word(input logic [7:0] idx);
      word_type w;
      w.opcode = ~OPC_BYTE;
      w.rx_byte = $urandom_range(0, 255);
      w.read_index = idx;
      return w;
   endfunction

   task automatic add_word(input word_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   // mode: 0 good CRC, 1 swapped CRC, 2 corrupted CRC.
   task automatic queue_frame(input int len_m1, input int mode, input int first_byte);
      logic [7:0] body[$];
      logic [15:0] crc;
      body.insert(body.size(), SYNC_BYTE);
      body.insert(body.size(), len_m1[7:0]);
      for (int i = 0; i <= len_m1; i++)
         body.insert(body.size(),
                     (i == 0 && first_byte >= 0) ? first_byte[7:0] : 8'($urandom));
      crc = CRC_INIT;
      foreach (body[i]) crc = crc_step(crc, body[i]);
      if (mode == 2) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      if (mode == 1) begin
         body.insert(body.size(), crc[15:8]);
         body.insert(body.size(), crc[7:0]);
      end else begin
         body.insert(body.size(), crc[7:0]);
         body.insert(body.size(), crc[15:8]);
      end
      foreach (body[i]) add_word(rx_word(body[i]));
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_bypass(input logic v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      bypass = v;
   endtask

   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.opcode <= 1'b0;
         req_ch.rx_byte <= 8'h00;
         req_ch.read_index <= 8'h00;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) predict_word(pending_words.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() > 0 && !hold_sender) begin
            req_ch.valid <= 1'b1;
            req_ch.opcode <= pending_words[0].opcode;
            req_ch.rx_byte <= pending_words[0].rx_byte;
            req_ch.read_index <= pending_words[0].read_index;
            send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
         end else req_ch.valid <= 1'b0;
      end
   end

   int sink_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_type got;
            got = {rsp_ch.result_kind, rsp_ch.payload_length, rsp_ch.message_type,
                   rsp_ch.crc_swapped, rsp_ch.crc_mismatch_bypassed, rsp_ch.calc_crc,
                   rsp_ch.frame_crc, rsp_ch.read_data, rsp_ch.read_out_of_range};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               failures++;
            end else begin
               result_type exp;
               exp = expected_results.pop_front();
               if (got !== exp) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp, got);
                  failures++;
               end
            end
            sink_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            rsp_ch.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      int kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Directed: read with nothing stored, noise before sync, extremes of length.
      add_word(read_word(8'd0));
      add_word(rx_word(8'h00));
      add_word(rx_word(8'h7E));
      queue_frame(0, 0, 0);
      add_word(read_word(8'd0));
      add_word(read_word(8'd1));
      add_word(read_word(8'd255));
      queue_frame(3, 1, 255);
      queue_frame(2, 2, 1);
      while (pending_words.size() > 10) @(posedge clock);
      hold_sender = 1;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      hold_sender = 0;
      wait_drained();
      queue_frame(255, 0, 8'hA5);
      add_word(read_word(8'd255));
      add_word(read_word(8'd128));
      wait_drained();
      write_bypass(1'b1);
      queue_frame(4, 2, -1);
      queue_frame(1, 1, -1);
      wait_drained();
      write_bypass(1'b0);
      // Overflow: a rejected frame leaves a short frame whose check point has passed.
      add_word(rx_word(SYNC_BYTE));
      add_word(rx_word(8'h05));
      add_word(rx_word(SYNC_BYTE));
      add_word(rx_word(8'h00));
      for (int i = 0; i < BUFFER_LIMIT; i++) add_word(rx_word(8'($urandom_range(0, 254))));
      wait_drained();
      for (int ph = 0; ph < 4; ph++) begin
         while (pending_words.size() < 250) begin
            kind = $urandom_range(0, 19);
            if (kind < 10) queue_frame($urandom_range(0, 12), $urandom_range(0, 2), -1);
            else if (kind == 10) queue_frame($urandom_range(0, 255), 0, -1);
            else if (kind < 16) add_word(read_word(
               ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 14)) : 8'($urandom)));
            else add_word(rx_word(
               ($urandom_range(0, 2) == 0) ? SYNC_BYTE : 8'($urandom)));
         end
         wait_drained();
         write_bypass(ph[0] == 1'b0);
      end
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
